// File: design/vcspe_pkg.sv
// Shared types and constants of the voxel chunk stream point extractor.
`timescale 1ns / 1ps
`default_nettype none

package vcspe_pkg;

  localparam int POSITION_WIDTH_DEFAULT = 32;

  localparam int FILE_LENGTH_WIDTH = 32;
  localparam int POINT_LIMIT_WIDTH = 24;
  localparam int CFG_DATA_WIDTH    = 32;
  localparam int COORD_WIDTH       = 8;
  localparam int POINT_NUM_WIDTH   = 24;
  localparam int STATUS_WIDTH      = 2;

  localparam logic [FILE_LENGTH_WIDTH-1:0] FILE_LENGTH_RESET = 32'd1;
  localparam logic [POINT_LIMIT_WIDTH-1:0] POINT_LIMIT_RESET = 24'd2000000;

  // Register indexes of the configuration port.
  localparam logic CFG_FILE_LENGTH = 1'b0;
  localparam logic CFG_POINT_LIMIT = 1'b1;

  // "VOX " and "XYZI", first file byte in the low bits.
  localparam logic [31:0] MAGIC_WORD = 32'h20584F56;
  localparam logic [31:0] ID_XYZI    = 32'h495A5958;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_END   = 1'b1;

  localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_BAD      = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_NO_POINT = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                          kind;
    logic [COORD_WIDTH-1:0]        coord_x;
    logic [COORD_WIDTH-1:0]        coord_y;
    logic [COORD_WIDTH-1:0]        coord_z;
    logic [POINT_NUM_WIDTH-1:0]    point_number;
    logic [STATUS_WIDTH-1:0]       status;
  } result_t;

  typedef struct packed {
    logic point_en;
    logic end_en;
  } push_t;

  typedef struct packed {
    logic                has_room;
    logic                not_empty;
    logic [QUEUE_CW-1:0] level;
  } queue_status_t;

endpackage

`default_nettype wire

// File: design/vcspe_parser.sv
// Front end: byte-wise VOX header and chunk walker that produces result items.
`timescale 1ns / 1ps
`default_nettype none

module vcspe_parser #(
  parameter int POSITION_WIDTH = vcspe_pkg::POSITION_WIDTH_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   take,
  input  wire logic [7:0]                             data_byte,
  input  wire logic [vcspe_pkg::FILE_LENGTH_WIDTH-1:0] file_length,
  input  wire logic [vcspe_pkg::POINT_LIMIT_WIDTH-1:0] point_limit,
  output vcspe_pkg::push_t                            push,
  output vcspe_pkg::result_t                          point_item,
  output vcspe_pkg::result_t                          end_item
);
  import vcspe_pkg::*;

  localparam int EW = (POSITION_WIDTH > FILE_LENGTH_WIDTH) ? POSITION_WIDTH : FILE_LENGTH_WIDTH;
  localparam int SW = EW + 2;

  typedef enum logic [2:0] {
    PH_MAGIC, PH_HEADER, PH_COUNT, PH_VOXEL, PH_SKIP, PH_DONE, PH_BAD
  } phase_t;

  phase_t                       phase, phase_next;
  logic [POSITION_WIDTH-1:0]    pos, pos_next;
  logic [63:0]                  hdr, hdr_next;
  logic [31:0]                  content, content_next;
  logic [POINT_LIMIT_WIDTH-1:0] vox_left, vox_left_next;
  logic [15:0]                  partial, partial_next;
  logic [3:0]                   fbi, fbi_next;
  logic [POINT_NUM_WIDTH-1:0]   made, made_next;

  logic [3:0]                   fbi_inc;
  logic [31:0]                  content_dec;
  logic [EW-1:0]                fl_ext;
  logic [POSITION_WIDTH-1:0]    end_pos;
  logic                         at_end;
  logic                         over_end;
  logic [31:0]                  chunk_id;
  logic [31:0]                  chunk_size;
  phase_t                       chunk_done_phase;
  logic [31:0]                  count_word;
  logic [31:0]                  room;
  logic [31:0]                  bound_a;
  logic [POINT_LIMIT_WIDTH-1:0] avail;
  logic [POINT_LIMIT_WIDTH-1:0] bounded;
  logic                         emit_point;
  logic [STATUS_WIDTH-1:0]      end_status;
  logic [POINT_NUM_WIDTH-1:0]   end_count;

  assign fbi_inc     = fbi + 4'd1;
  assign content_dec = content - 32'd1;
  assign chunk_id    = hdr[31:0];
  assign chunk_size  = hdr[63:32];
  assign fl_ext      = EW'(file_length);
  assign end_pos     = POSITION_WIDTH'(fl_ext - EW'(1));
  assign at_end      = (pos == end_pos);
  assign over_end    = (SW'(pos) + SW'(1) + SW'(chunk_size)) > SW'(file_length);
  assign chunk_done_phase = (made >= point_limit) ? PH_DONE : PH_HEADER;

  // Voxel count bound: min(count, room left in content, points still allowed).
  assign count_word = {data_byte, hdr[23:0]};
  assign room       = {2'b00, content_dec[31:2]};
  assign bound_a    = (count_word < room) ? count_word : room;
  assign avail      = (point_limit > made) ? (point_limit - made) : '0;
  assign bounded    = (32'(avail) < bound_a) ? avail : bound_a[POINT_LIMIT_WIDTH-1:0];

  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    hdr_next      = hdr;
    content_next  = content;
    vox_left_next = vox_left;
    partial_next  = partial;
    fbi_next      = fbi;
    made_next     = made;
    emit_point    = 1'b0;
    end_status    = STATUS_OK;
    end_count     = '0;

    case (phase)
      PH_MAGIC: begin
        if ((pos[POSITION_WIDTH-1:2] == '0) && (data_byte != MAGIC_WORD[8*pos[1:0] +: 8])) begin
          phase_next = PH_BAD;
        end else if (pos == POSITION_WIDTH'(7)) begin
          phase_next = PH_HEADER;
          hdr_next   = '0;
          fbi_next   = '0;
        end
      end
      PH_HEADER: begin
        if (!fbi[3]) begin
          hdr_next[8*fbi[2:0] +: 8] = data_byte;
        end
        fbi_next = fbi_inc;
        if (fbi_inc >= 4'd12) begin
          fbi_next = '0;
          hdr_next = '0;
          if (over_end) begin
            phase_next = PH_DONE;
          end else if (chunk_size == 32'd0) begin
            phase_next = chunk_done_phase;
          end else begin
            content_next = chunk_size;
            phase_next   = ((chunk_id == ID_XYZI) && (chunk_size >= 32'd4)) ? PH_COUNT : PH_SKIP;
          end
        end
      end
      PH_COUNT: begin
        content_next = content_dec;
        hdr_next[8*fbi[1:0] +: 8] = data_byte;
        fbi_next = fbi_inc;
        if (fbi_inc >= 4'd4) begin
          vox_left_next = bounded;
          hdr_next      = '0;
          fbi_next      = '0;
          if (bounded != '0) begin
            phase_next = PH_VOXEL;
          end else if (content_dec != 32'd0) begin
            phase_next = PH_SKIP;
          end else begin
            phase_next = chunk_done_phase;
          end
        end
      end
      PH_VOXEL: begin
        content_next = content_dec;
        case (fbi[1:0])
          2'd0: begin
            partial_next = {8'h00, data_byte};
          end
          2'd1: begin
            partial_next[15:8] = data_byte;
          end
          2'd2: begin
            emit_point = 1'b1;
            made_next  = made + POINT_NUM_WIDTH'(1);
          end
          default: begin
          end
        endcase
        fbi_next = fbi_inc;
        if (fbi_inc >= 4'd4) begin
          fbi_next      = '0;
          partial_next  = '0;
          vox_left_next = vox_left - POINT_LIMIT_WIDTH'(1);
          if (vox_left == POINT_LIMIT_WIDTH'(1)) begin
            phase_next = (content_dec != 32'd0) ? PH_SKIP : chunk_done_phase;
          end
        end
      end
      PH_SKIP: begin
        content_next = content_dec;
        if (content_dec == 32'd0) begin
          phase_next = chunk_done_phase;
          hdr_next   = '0;
          fbi_next   = '0;
        end
      end
      default: begin
      end
    endcase

    if ((phase_next == PH_BAD) || (phase_next == PH_MAGIC) || (file_length < 32'd8)) begin
      end_status = STATUS_BAD;
    end else if (made_next != '0) begin
      end_status = STATUS_OK;
    end else begin
      end_status = STATUS_NO_POINT;
    end

    // The end result reports the total including a point made on the same byte.
    end_count = made_next;

    if (at_end) begin
      phase_next    = PH_MAGIC;
      pos_next      = '0;
      hdr_next      = '0;
      content_next  = '0;
      vox_left_next = '0;
      partial_next  = '0;
      fbi_next      = '0;
      made_next     = '0;
    end else begin
      pos_next = pos + POSITION_WIDTH'(1);
    end
  end

  assign push.point_en = take & emit_point;
  assign push.end_en   = take & at_end;

  assign point_item.kind         = KIND_POINT;
  assign point_item.coord_x      = partial[7:0];
  assign point_item.coord_y      = data_byte;
  assign point_item.coord_z      = partial[15:8];
  assign point_item.point_number = made;
  assign point_item.status       = STATUS_OK;

  always_comb begin
    end_item              = '0;
    end_item.kind         = KIND_END;
    end_item.point_number = end_count;
    end_item.status       = end_status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_MAGIC;
      pos      <= '0;
      hdr      <= '0;
      content  <= '0;
      vox_left <= '0;
      partial  <= '0;
      fbi      <= '0;
      made     <= '0;
    end else if (take) begin
      phase    <= phase_next;
      pos      <= pos_next;
      hdr      <= hdr_next;
      content  <= content_next;
      vox_left <= vox_left_next;
      partial  <= partial_next;
      fbi      <= fbi_next;
      made     <= made_next;
    end
  end

endmodule

`default_nettype wire

// File: design/vcspe_queue.sv
// Back end: small result queue taking up to two items a cycle and presenting one.
`timescale 1ns / 1ps
`default_nettype none

module vcspe_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire vcspe_pkg::push_t    push,
  input  wire vcspe_pkg::result_t  point_item,
  input  wire vcspe_pkg::result_t  end_item,
  input  wire logic                pop_ready,
  output vcspe_pkg::result_t       head,
  output vcspe_pkg::queue_status_t qstat
);
  import vcspe_pkg::*;

  result_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr, wr_ptr_next;
  logic [QUEUE_AW-1:0]  rd_ptr, rd_ptr_next;
  logic [QUEUE_AW-1:0]  end_slot;
  logic [QUEUE_CW-1:0]  level, level_next;
  logic [QUEUE_CW-1:0]  n_push;
  logic                 pop;

  assign n_push   = QUEUE_CW'(push.point_en) + QUEUE_CW'(push.end_en);
  assign pop      = (level != '0) && pop_ready;
  assign end_slot = wr_ptr + QUEUE_AW'(push.point_en);

  assign wr_ptr_next = wr_ptr + QUEUE_AW'(n_push);
  assign rd_ptr_next = rd_ptr + QUEUE_AW'(pop);
  assign level_next  = level + n_push - QUEUE_CW'(pop);

  assign head            = slots[rd_ptr];
  assign qstat.not_empty = (level != '0);
  assign qstat.has_room  = (level <= QUEUE_CW'(QUEUE_DEPTH - 2));
  assign qstat.level     = level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level  <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.point_en) begin
      slots[wr_ptr] <= point_item;
    end
    if (push.end_en) begin
      slots[end_slot] <= end_item;
    end
  end

endmodule

`default_nettype wire

// File: design/voxel_chunk_stream_point_extractor.sv
// Top level of the voxel chunk stream point extractor.
`timescale 1ns / 1ps
`default_nettype none

// The block takes a VOX file one byte per item and returns its voxel points. While the queue has
// room, a steady stream runs at one byte per clock; the walker's per-byte update of its position,
// chunk and voxel counters is what fixes that figure. Result
// items go into a four-entry queue that takes up to two items per byte (a point and the end
// result can come from the same byte), so input is refused only while that queue holds more
// than two items waiting on the output side. Configure file_length and point_limit while no
// file is in flight; the end result arrives on the last byte and the next byte starts a new
// file.
module voxel_chunk_stream_point_extractor #(
  parameter int POSITION_WIDTH = vcspe_pkg::POSITION_WIDTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Byte stream.
  input  wire logic                                  in_valid,
  output wire logic                                  in_ready,
  input  wire logic [7:0]                            data_byte,
  // Result stream.
  output wire logic                                  out_valid,
  input  wire logic                                  out_ready,
  output wire logic                                  kind,
  output wire logic [vcspe_pkg::COORD_WIDTH-1:0]     coord_x,
  output wire logic [vcspe_pkg::COORD_WIDTH-1:0]     coord_y,
  output wire logic [vcspe_pkg::COORD_WIDTH-1:0]     coord_z,
  output wire logic [vcspe_pkg::POINT_NUM_WIDTH-1:0] point_number,
  output wire logic [vcspe_pkg::STATUS_WIDTH-1:0]    status,
  // Configuration writes.
  input  wire logic                                  cfg_write,
  input  wire logic                                  cfg_index,
  input  wire logic [vcspe_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import vcspe_pkg::*;

  logic [FILE_LENGTH_WIDTH-1:0] file_length;
  logic [POINT_LIMIT_WIDTH-1:0] point_limit;

  logic          take;
  push_t         push;
  result_t       point_item;
  result_t       end_item;
  result_t       head;
  queue_status_t qstat;

  // Configuration registers are written directly; the walker sees them on the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= FILE_LENGTH_RESET;
      point_limit <= POINT_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FILE_LENGTH: file_length <= cfg_data[FILE_LENGTH_WIDTH-1:0];
        CFG_POINT_LIMIT: point_limit <= cfg_data[POINT_LIMIT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // A byte is taken whenever the queue can absorb the worst case of two results.
  assign in_ready = qstat.has_room;
  assign take     = in_valid & in_ready;

  vcspe_parser #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (data_byte),
    .file_length (file_length),
    .point_limit (point_limit),
    .push        (push),
    .point_item  (point_item),
    .end_item    (end_item)
  );

  vcspe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .point_item (point_item),
    .end_item   (end_item),
    .pop_ready  (out_ready),
    .head       (head),
    .qstat      (qstat)
  );

  assign out_valid    = qstat.not_empty;
  assign kind         = head.kind;
  assign coord_x      = head.coord_x;
  assign coord_y      = head.coord_y;
  assign coord_z      = head.coord_z;
  assign point_number = head.point_number;
  assign status       = head.status;

  // The queue never holds more items than it has entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.level <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("result queue over capacity");

  // A point result always carries the ok status.
  a_point_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_POINT)) |-> (status == STATUS_OK))
    else $error("point result with nonzero status");

  // An end result carries zero coordinates.
  a_end_coords: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_END)) |-> ((coord_x == '0) && (coord_y == '0) && (coord_z == '0)))
    else $error("end result with nonzero coordinates");

  // A byte that yields two results needs two free entries when it is taken.
  a_room_on_take: assert property (@(posedge clk) disable iff (rst)
    (push.point_en && push.end_en) |-> (qstat.level <= QUEUE_CW'(QUEUE_DEPTH - 2)))
    else $error("double push without room");

endmodule

`default_nettype wire
